// ===== sv/hpfc_pkg.sv =====
// Shared types and constants for the binary16 format converter.
`timescale 1ns / 1ps
package hpfc_pkg;

  typedef enum logic [1:0] {
    FUNC_S2H = 2'd0,
    FUNC_D2H = 2'd1,
    FUNC_H2S = 2'd2,
    FUNC_H2D = 2'd3
  } func_t;

  typedef struct packed {
    logic overflow;
    logic underflow;
  } hpfc_flags_t;

  // Register word index and reset value
  localparam logic REG_ROUND_TIES_EVEN = 1'b0;
  localparam logic RTE_RESET           = 1'b1;

  // Double exponent landmarks for narrowing to half
  localparam logic [10:0] D_EXP_MAX      = 11'h7ff;
  localparam logic [10:0] D_EXP_OVF      = 11'h40f;  // 2^16 and up overflows
  localparam logic [10:0] D_EXP_TINY     = 11'h3e6;  // below 2^-25 rounds to zero
  localparam logic [10:0] D_EXP_SUB_MAX  = 11'h3f0;  // half subnormal range top
  localparam logic [10:0] D_SUB_SHIFT    = 11'd1009; // 1051 - e - 42
  localparam logic [10:0] S2D_EXP_ADJ    = 11'd896;  // 1023 - 127
  localparam logic [14:0] H_INF          = 15'h7c00;

  // Widening exponent offsets
  localparam logic [7:0]  S_EXP_MAX      = 8'hff;
  localparam logic [7:0]  S_SUB_BASE     = 8'd103;   // 127 - 24
  localparam logic [7:0]  S_NORM_ADJ     = 8'd112;   // 127 - 15
  localparam logic [10:0] D_SUB_BASE     = 11'd999;  // 1023 - 24
  localparam logic [10:0] D_NORM_ADJ     = 11'd1008; // 1023 - 15
  localparam logic [4:0]  H_EXP_MAX      = 5'h1f;

endpackage

// ===== sv/half_precision_format_converter.sv =====
// Top level of the binary16 format converter: handshake, registers, datapath.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+--------------------------------
//  in_     | input     | in_valid/in_ready   | in_func, in_operand
//  out_    | output    | out_valid/out_ready | out_result, out_overflow, out_underflow
//  cfg_    | input     | APB, pready high    | word 0: round_ties_even (bit 0)
//
// Structure: one input register, then the conversion logic into the result
// register. One item per cycle sustained while out_ready is high, set by the
// single-pass datapath between those two registers.
// Reset (synchronous, rst_n low) empties both stages and sets ties-to-even.
// A stalled out_ready fills the result register, then the input register;
// in_ready drops only when both are full.
`timescale 1ns / 1ps
module half_precision_format_converter (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  hpfc_pkg::func_t       in_func,
  input  logic [63:0]           in_operand,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [63:0]           out_result,
  output logic                  out_overflow,
  output logic                  out_underflow,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [2:0]            cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);
  import hpfc_pkg::*;

  // config register
  logic rte_r;
  logic cfg_wr;

  // input stage
  logic        s1_valid_r;
  func_t       s1_func_r;
  logic [63:0] s1_operand_r;

  // result stage
  logic        out_valid_r;
  logic [63:0] out_result_r;
  hpfc_flags_t out_flags_r;

  logic        out_free;
  logic        s1_load;
  logic        out_load;

  logic [15:0] nar_result;
  hpfc_flags_t nar_flags;
  logic [63:0] wid_result;
  logic [63:0] res_nxt;
  hpfc_flags_t flags_nxt;

  // APB: word 0 holds the rounding control
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_ROUND_TIES_EVEN) ? {31'b0, rte_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rte_r <= RTE_RESET;
    end else if (cfg_wr && (cfg_paddr[2] == REG_ROUND_TIES_EVEN)) begin
      rte_r <= cfg_pwdata[0];
    end
  end

  // Pipeline control: each stage moves when the one after it has room
  assign out_free = ~out_valid_r | out_ready;
  assign in_ready = ~s1_valid_r | out_free;
  assign s1_load  = in_valid & in_ready;
  assign out_load = s1_valid_r & out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_func_r    <= in_func;
      s1_operand_r <= in_operand;
    end
  end

  // Datapath
  hpfc_narrow u_narrow (
    .rte_i     (rte_r),
    .func_i    (s1_func_r),
    .operand_i (s1_operand_r),
    .result_o  (nar_result),
    .flags_o   (nar_flags)
  );

  hpfc_widen u_widen (
    .func_i   (s1_func_r),
    .half_i   (s1_operand_r[15:0]),
    .result_o (wid_result)
  );

  // Widening never raises a flag
  always_comb begin
    case (s1_func_r)
      FUNC_S2H, FUNC_D2H: begin
        res_nxt   = {48'b0, nar_result};
        flags_nxt = nar_flags;
      end
      default: begin
        res_nxt   = wid_result;
        flags_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_result_r <= res_nxt;
      out_flags_r  <= flags_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_result    = out_result_r;
  assign out_overflow  = out_flags_r.overflow;
  assign out_underflow = out_flags_r.underflow;

endmodule

// ===== sv/hpfc_narrow.sv =====
// Single or double to half narrowing with rounding and flags.
`timescale 1ns / 1ps
module hpfc_narrow (
  input  logic                 rte_i,
  input  hpfc_pkg::func_t      func_i,
  input  logic [63:0]          operand_i,
  output logic [15:0]          result_o,
  output hpfc_pkg::hpfc_flags_t flags_o
);
  import hpfc_pkg::*;

  logic        sign;
  logic [10:0] exp;
  logic [51:0] man;
  logic        s_zero;

  // subnormal path
  logic [10:0] sub_k;
  logic [21:0] sub_sh;
  logic [10:0] sub_keep;
  logic        sub_guard;
  logic        sub_sticky;
  logic        sub_up;
  logic [10:0] sub_val;

  // normal path
  logic [4:0]  n_exp;
  logic        n_up;
  logic [14:0] n_val;

  logic [9:0]  nan_pay;

  // Bring a single source onto the double grid
  always_comb begin
    s_zero = 1'b0;
    if (func_i == FUNC_S2H) begin
      sign = operand_i[31];
      man  = {operand_i[22:0], 29'b0};
      if (operand_i[30:23] == 8'hff) begin
        exp = D_EXP_MAX;
      end else begin
        exp = {3'b0, operand_i[30:23]} + S2D_EXP_ADJ;
      end
      s_zero = (operand_i[30:23] == 8'h00);
    end else begin
      sign = operand_i[63];
      exp  = operand_i[62:52];
      man  = operand_i[51:0];
    end
  end

  always_comb begin
    sub_k      = D_SUB_SHIFT - exp;
    sub_sh     = {1'b1, man[51:42], 11'b0} >> sub_k[3:0];
    sub_keep   = sub_sh[21:11];
    sub_guard  = sub_sh[10];
    sub_sticky = (|sub_sh[9:0]) | (|man[41:0]);
    sub_up     = sub_guard & (sub_sticky | ~rte_i | sub_keep[0]);
    sub_val    = sub_keep + {10'b0, sub_up};

    n_exp = 5'(exp - D_EXP_SUB_MAX);
    n_up  = man[41] & ((|man[40:0]) | ~rte_i | man[42]);
    n_val = {n_exp, man[51:42]} + {14'b0, n_up};

    nan_pay = (man[51:42] == 10'd0) ? 10'd1 : man[51:42];
  end

  always_comb begin
    flags_o = '0;
    if (s_zero) begin
      result_o           = {sign, 15'b0};
      flags_o.underflow  = (man != 52'd0);
    end else if (exp == D_EXP_MAX) begin
      if (man != 52'd0) begin
        result_o = {sign, H_INF[14:10], nan_pay};
      end else begin
        result_o = {sign, H_INF};
      end
    end else if (exp >= D_EXP_OVF) begin
      result_o         = {sign, H_INF};
      flags_o.overflow = 1'b1;
    end else if (exp < D_EXP_TINY) begin
      result_o          = {sign, 15'b0};
      flags_o.underflow = (exp != 11'd0) || (man != 52'd0);
    end else if (exp <= D_EXP_SUB_MAX) begin
      // tininess before rounding: flag any lost bits
      result_o          = {sign, 4'b0, sub_val};
      flags_o.underflow = sub_guard | sub_sticky;
    end else begin
      if (n_val >= H_INF) begin
        result_o         = {sign, H_INF};
        flags_o.overflow = 1'b1;
      end else begin
        result_o = {sign, n_val};
      end
    end
  end

endmodule

// ===== sv/hpfc_widen.sv =====
// Half to single or double widening, exact.
`timescale 1ns / 1ps
module hpfc_widen (
  input  hpfc_pkg::func_t func_i,
  input  logic [15:0]     half_i,
  output logic [63:0]     result_o
);
  import hpfc_pkg::*;

  logic        sign;
  logic [4:0]  e;
  logic [9:0]  m;
  logic [3:0]  p;
  logic [19:0] m_wide;
  logic [9:0]  m_norm;
  logic [9:0]  frac;
  logic [7:0]  s_exp;
  logic [10:0] d_exp;

  always_comb begin
    sign = half_i[15];
    e    = half_i[14:10];
    m    = half_i[9:0];
    // position of the leading one of a subnormal fraction
    p = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (m[i]) begin
        p = 4'(i);
      end
    end
    m_wide = {10'b0, m} << (4'd10 - p);
    m_norm = m_wide[9:0];
  end

  always_comb begin
    if (e == 5'd0) begin
      frac  = m_norm;
      s_exp = S_SUB_BASE + {4'b0, p};
      d_exp = D_SUB_BASE + {7'b0, p};
      if (m == 10'd0) begin
        frac  = 10'd0;
        s_exp = 8'd0;
        d_exp = 11'd0;
      end
    end else if (e == H_EXP_MAX) begin
      frac  = m;
      s_exp = S_EXP_MAX;
      d_exp = D_EXP_MAX;
    end else begin
      frac  = m;
      s_exp = {3'b0, e} + S_NORM_ADJ;
      d_exp = {6'b0, e} + D_NORM_ADJ;
    end
  end

  always_comb begin
    if (func_i == FUNC_H2D) begin
      result_o = {sign, d_exp, frac, 42'b0};
    end else begin
      result_o = {32'b0, sign, s_exp, frac, 13'b0};
    end
  end

endmodule
